FILE: rtl/ppsp_pkg.sv
// ----------------------------------------------------------------------------
// ppsp_pkg
// Shared types and codes of the preemptive slot pool: beat payloads, status
// and function codes, register indexes and the slot store word.
// ----------------------------------------------------------------------------
package ppsp_pkg;

    localparam int PLAIN_SLOTS_DEF = 16;
    localparam int CUBE_SLOTS_DEF  = 16;

    localparam int CNT_W      = 5;
    localparam int PRIO_W     = 9;
    localparam int GEN_W      = 8;
    localparam int SLOT_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(16);

    // func codes
    localparam logic [1:0] FN_REQUEST = 2'd0;
    localparam logic [1:0] FN_FREE    = 2'd1;
    localparam logic [1:0] FN_UPDATE  = 2'd2;

    // status codes
    localparam logic [1:0] ST_NEW     = 2'd0;
    localparam logic [1:0] ST_RECLAIM = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAIN_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUBE_LIMIT  = 2'd2;

    // priority of a free slot
    localparam logic signed [PRIO_W-1:0] PRIO_FREE = -9'sd1;

    typedef struct packed {
        logic [1:0]        func;
        logic              cube_pool;
        logic [7:0]        priority_req;
        logic [SLOT_W-1:0] slot_index;
    } ppsp_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] granted_slot;
        logic [GEN_W-1:0]  handle_gen;
    } ppsp_out_t;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [GEN_W-1:0]         gen;
    } slot_word_t;

endpackage

FILE: rtl/ppsp_slot_mem.sv
// ----------------------------------------------------------------------------
// ppsp_slot_mem
// Slot store: priority and generation per slot, one write and one registered
// read per cycle. Generations read as zero until the entry is first written.
// ----------------------------------------------------------------------------
module ppsp_slot_mem
    import ppsp_pkg::*;
#(
    parameter int DEPTH = PLAIN_SLOTS_DEF + CUBE_SLOTS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output slot_word_t    rd_word,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  slot_word_t    wr_word
);

    slot_word_t       slot_mem [DEPTH];
    slot_word_t       rd_word_reg;
    logic             rd_valid_reg;
    logic [DEPTH-1:0] gen_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_word;
        end
        if (rd_en) begin
            rd_word_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                gen_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= gen_valid_reg[rd_addr];
            end
        end
    end

    assign rd_word.prio = rd_word_reg.prio;
    assign rd_word.gen  = rd_valid_reg ? rd_word_reg.gen : '0;

endmodule

FILE: rtl/priority_preempt_slot_pool_unit.sv
// ----------------------------------------------------------------------------
// priority_preempt_slot_pool_unit
// Preemptive slot allocator over a plain and a cube pool, run by a small
// microprogram over a slot store.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A request scans the created slots of its
// pool, each slot by a read of the slot store, then a compare against its
// registered read data; a hit on slot j ends the scan there. A request
// refused for a full pool has scanned all created slots first. Free, update
// and a request refused while disabled do not scan. The next beat is taken
// once the result sits in the output register, even if the consumer has
// not taken it.
// Generations start at zero after reset without a clearing pass.
module priority_preempt_slot_pool_unit
    import ppsp_pkg::*;
#(
    parameter int PLAIN_SLOTS = PLAIN_SLOTS_DEF,
    parameter int CUBE_SLOTS  = CUBE_SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ppsp_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ppsp_out_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH   = PLAIN_SLOTS + CUBE_SLOTS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] PLAIN_CAP =
        CNT_W'((PLAIN_SLOTS > CNT_MAX) ? CNT_MAX : PLAIN_SLOTS);
    localparam logic [CNT_W-1:0] CUBE_CAP =
        CNT_W'((CUBE_SLOTS > CNT_MAX) ? CNT_MAX : CUBE_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_REQ_CHK, S_SCAN_RD, S_SCAN_CMP, S_RECLAIM,
        S_APPEND_RD, S_APPEND_WR, S_MOD_RD, S_MOD_WR, S_REFUSE, S_EMIT
    } step_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_ACCEPT, OP_SCAN_RD, OP_SCAN_CMP, OP_RECLAIM, OP_APPEND_RD,
        OP_APPEND_WR, OP_MOD_RD, OP_MOD_WR, OP_REFUSE, OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER, C_ALWAYS, C_ACCEPT, C_NOT_REQ, C_DISABLED, C_SCAN_END,
        C_MISS, C_FULL, C_BAD_MOD, C_OUT_FREE
    } cond_t;

    // hold: stay on this step while the condition is false
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        logic  hold;
    } uword_t;

    function automatic uword_t ucode_rom(step_t s);
        uword_t w;
        begin
            unique case (s)
                S_IDLE:      w = '{OP_ACCEPT,    C_ACCEPT,   S_DECODE,    1'b1};
                S_DECODE:    w = '{OP_NONE,      C_NOT_REQ,  S_MOD_RD,    1'b0};
                S_REQ_CHK:   w = '{OP_NONE,      C_DISABLED, S_REFUSE,    1'b0};
                S_SCAN_RD:   w = '{OP_SCAN_RD,   C_SCAN_END, S_APPEND_RD, 1'b0};
                S_SCAN_CMP:  w = '{OP_SCAN_CMP,  C_MISS,     S_SCAN_RD,   1'b0};
                S_RECLAIM:   w = '{OP_RECLAIM,   C_ALWAYS,   S_EMIT,      1'b0};
                S_APPEND_RD: w = '{OP_APPEND_RD, C_FULL,     S_REFUSE,    1'b0};
                S_APPEND_WR: w = '{OP_APPEND_WR, C_ALWAYS,   S_EMIT,      1'b0};
                S_MOD_RD:    w = '{OP_MOD_RD,    C_BAD_MOD,  S_REFUSE,    1'b0};
                S_MOD_WR:    w = '{OP_MOD_WR,    C_ALWAYS,   S_EMIT,      1'b0};
                S_REFUSE:    w = '{OP_REFUSE,    C_NEVER,    S_EMIT,      1'b0};
                S_EMIT:      w = '{OP_EMIT,      C_OUT_FREE, S_IDLE,      1'b1};
                default:     w = '{OP_NONE,      C_ALWAYS,   S_IDLE,      1'b0};
            endcase
            return w;
        end
    endfunction

    function automatic logic [AW-1:0] slot_addr(logic cube, logic [CNT_W-1:0] slot);
        logic [AW-1:0] a;
        begin
            if (cube) begin
                a = AW'(PLAIN_SLOTS + int'(slot));
            end else begin
                a = AW'(slot);
            end
            return a;
        end
    endfunction

    step_t      upc_reg, upc_next;
    ppsp_in_t   item_reg;
    logic [CNT_W-1:0] i_reg;
    ppsp_out_t  res_reg;
    ppsp_out_t  out_reg;
    logic       m_valid_reg;
    logic       enable_reg;
    logic [CNT_W-1:0] plain_limit_reg, cube_limit_reg;
    logic [CNT_W-1:0] plain_count_reg, cube_count_reg;

    uword_t     uw;
    logic       cond_true;
    logic       is_cube;
    logic [CNT_W-1:0] cur_count, cur_limit, cur_cap, limit_eff, idx_ext, rd_slot;
    logic signed [PRIO_W-1:0] req_prio;
    logic       hit, full, mod_ok, out_free;
    logic [GEN_W-1:0] gen_inc;

    logic       rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    slot_word_t rd_word, wr_word;

    assign uw        = ucode_rom(upc_reg);
    assign is_cube   = item_reg.cube_pool;
    assign cur_count = is_cube ? cube_count_reg : plain_count_reg;
    assign cur_limit = is_cube ? cube_limit_reg : plain_limit_reg;
    assign cur_cap   = is_cube ? CUBE_CAP : PLAIN_CAP;
    assign limit_eff = (cur_limit > cur_cap) ? cur_cap : cur_limit;
    assign full      = cur_count >= limit_eff;
    assign idx_ext   = CNT_W'(item_reg.slot_index);
    assign mod_ok    = ((item_reg.func == FN_FREE) || (item_reg.func == FN_UPDATE))
                       && (idx_ext < cur_count);
    assign req_prio  = $signed({1'b0, item_reg.priority_req});
    assign hit       = req_prio > rd_word.prio;
    assign gen_inc   = rd_word.gen + 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        unique case (uw.cond)
            C_NEVER:    cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_ACCEPT:   cond_true = s_valid;
            C_NOT_REQ:  cond_true = item_reg.func != FN_REQUEST;
            C_DISABLED: cond_true = !enable_reg;
            C_SCAN_END: cond_true = i_reg >= cur_count;
            C_MISS:     cond_true = !hit;
            C_FULL:     cond_true = full;
            C_BAD_MOD:  cond_true = !mod_ok;
            C_OUT_FREE: cond_true = out_free;
            default:    cond_true = 1'b1;
        endcase
    end

    always_comb begin
        if (cond_true) begin
            upc_next = uw.target;
        end else if (uw.hold) begin
            upc_next = upc_reg;
        end else begin
            upc_next = step_t'(upc_reg + 1'b1);
        end
    end

    // slot store control
    always_comb begin
        rd_en   = 1'b0;
        rd_slot = i_reg;
        wr_en   = 1'b0;
        wr_word = '{prio: req_prio, gen: rd_word.gen};
        unique case (uw.op)
            OP_SCAN_RD: begin
                rd_en = 1'b1;
            end
            OP_APPEND_RD: begin
                rd_en   = !full;
                rd_slot = cur_count;
            end
            OP_MOD_RD: begin
                rd_en   = mod_ok;
                rd_slot = idx_ext;
            end
            OP_RECLAIM: begin
                wr_en   = 1'b1;
                wr_word = '{prio: req_prio, gen: gen_inc};
            end
            OP_APPEND_WR: begin
                wr_en = 1'b1;
            end
            OP_MOD_WR: begin
                wr_en = 1'b1;
                if (item_reg.func == FN_FREE) begin
                    wr_word = '{prio: PRIO_FREE, gen: gen_inc};
                end
            end
            default: begin
            end
        endcase
    end

    assign rd_addr = slot_addr(is_cube, rd_slot);
    assign wr_addr = slot_addr(is_cube, i_reg);

    ppsp_slot_mem #(
        .DEPTH(DEPTH)
    ) u_slot_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_word (rd_word),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_word (wr_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg         <= S_IDLE;
            m_valid_reg     <= 1'b0;
            enable_reg      <= 1'b1;
            plain_limit_reg <= LIMIT_RESET;
            cube_limit_reg  <= LIMIT_RESET;
            plain_count_reg <= '0;
            cube_count_reg  <= '0;
        end else begin
            upc_reg <= upc_next;

            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_ENABLE:      enable_reg      <= cfg_data[0];
                    CFG_PLAIN_LIMIT: plain_limit_reg <= cfg_data;
                    CFG_CUBE_LIMIT:  cube_limit_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end

            if ((uw.op == OP_EMIT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (uw.op)
                OP_ACCEPT: begin
                    if (s_valid) begin
                        item_reg <= s_data;
                        i_reg    <= '0;
                    end
                end
                OP_SCAN_CMP: begin
                    if (!hit) begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                OP_RECLAIM: begin
                    res_reg <= '{ST_RECLAIM, i_reg[SLOT_W-1:0], gen_inc};
                end
                OP_APPEND_RD: begin
                    i_reg <= cur_count;
                end
                OP_APPEND_WR: begin
                    if (is_cube) begin
                        cube_count_reg <= cube_count_reg + 1'b1;
                    end else begin
                        plain_count_reg <= plain_count_reg + 1'b1;
                    end
                    res_reg <= '{ST_NEW, i_reg[SLOT_W-1:0], rd_word.gen};
                end
                OP_MOD_RD: begin
                    i_reg <= idx_ext;
                end
                OP_MOD_WR: begin
                    res_reg <= '{ST_DONE, i_reg[SLOT_W-1:0], wr_word.gen};
                end
                OP_REFUSE: begin
                    res_reg <= '{ST_REFUSED, '0, '0};
                end
                OP_EMIT: begin
                    if (out_free) begin
                        out_reg <= res_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign s_ready   = (uw.op == OP_ACCEPT);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (upc_reg == S_DECODE))
        else $error("accepted beat did not enter decode");

    a_reclaim_lower: assert property (@(posedge aclk) disable iff (!aresetn)
        (uw.op == OP_RECLAIM) |-> hit)
        else $error("reclaimed a slot that does not hold a lower priority");

    a_slot_created: assert property (@(posedge aclk) disable iff (!aresetn)
        ((uw.op == OP_RECLAIM) || (uw.op == OP_MOD_WR)) |-> (i_reg < cur_count))
        else $error("write to a slot that was never created");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (plain_count_reg <= PLAIN_CAP) && (cube_count_reg <= CUBE_CAP))
        else $error("pool count beyond pool size");

    a_emit_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ((uw.op == OP_EMIT) && out_free) |=> (m_valid && (upc_reg == S_IDLE)))
        else $error("result not loaded into output register");

endmodule
